FILE: hdl/fbfa_pkg.sv
// Shared types and constants of the fixed block free-list allocator.
package fbfa_pkg;

	localparam int ADDR_W    = 32;
	localparam int BB_W      = 25;
	localparam int SIZE_W    = 26;
	localparam int CNT_W     = 11;
	localparam int CFG_IDX_W = 2;
	localparam int DIV_CNT_W = $clog2(ADDR_W);

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POOL_BASE     = 2'd0,
		REG_BLOCK_BYTES   = 2'd1,
		REG_BLOCKS_IN_USE = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_CLEAR,
		S_IDLE,
		S_POP_RD,
		S_POP_WR,
		S_POP_SUM,
		S_FREE_CHK,
		S_FREE_DIV,
		S_FREE_PUSH
	} state_t;

	typedef enum logic [1:0] {
		RES_NONE,
		RES_ALLOC,
		RES_FREE
	} res_t;

	typedef struct packed {
		logic init;
		logic sweep;
		logic accept;
		logic pop;
		logic push;
		logic div_free;
		logic finish;
		res_t res;
	} ctrl_cmd_t;

	typedef struct packed {
		logic size_wr;
		logic count_wr;
		logic op_free;
		logic top_ok;
		logic addr_ok;
		logic idx_ok;
		logic div_done;
		logic sweep_last;
	} ctrl_stat_t;

endpackage

FILE: hdl/fbfa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module fbfa_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/fbfa_div.sv
// Restoring divider that produces one quotient bit per cycle.
module fbfa_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [fbfa_pkg::ADDR_W-1:0] dividend,
	input  logic [fbfa_pkg::SIZE_W-1:0] divisor,
	output logic                        done,
	output logic [fbfa_pkg::ADDR_W-1:0] quotient
);
	import fbfa_pkg::*;

	logic                 act_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [SIZE_W-1:0]    rem_q;
	logic [SIZE_W-1:0]    dvs_q;
	logic [ADDR_W-1:0]    quo_q;
	logic [SIZE_W:0]      shifted;
	logic [SIZE_W+1:0]    diff;
	logic                 borrow;
	logic                 last;

	assign shifted = {rem_q, quo_q[ADDR_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign borrow  = diff[SIZE_W+1];
	assign last    = (cnt_q == DIV_CNT_W'(ADDR_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			act_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= act_q && last;
			if (act_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					act_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (act_q) begin
			rem_q <= borrow ? shifted[SIZE_W-1:0] : diff[SIZE_W-1:0];
			quo_q <= {quo_q[ADDR_W-2:0], ~borrow};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: hdl/fbfa_ctrl.sv
// Controller state machine of the allocator: sequencing of clear, allocate and free.
module fbfa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  fbfa_pkg::ctrl_stat_t stat,
	output fbfa_pkg::ctrl_cmd_t  cmd
);
	import fbfa_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   round_act_q;

	// After a block_bytes write, the rounded block size is registered first as a line count and then as the size.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			round_act_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			round_act_q <= stat.size_wr;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_INIT: begin
				if (!stat.count_wr) begin
					state_nxt = S_CLEAR;
				end
			end
			S_CLEAR: begin
				if (stat.count_wr) begin
					state_nxt = S_INIT;
				end else if (stat.sweep_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (stat.count_wr) begin
					state_nxt = S_INIT;
				end else if (start && !round_act_q) begin
					state_nxt = stat.op_free ? S_FREE_CHK : S_POP_RD;
				end
			end
			S_POP_RD:    state_nxt = stat.top_ok ? S_POP_WR : S_IDLE;
			S_POP_WR:    state_nxt = S_POP_SUM;
			S_POP_SUM:   state_nxt = S_IDLE;
			S_FREE_CHK:  state_nxt = stat.addr_ok ? S_FREE_DIV : S_IDLE;
			S_FREE_DIV: begin
				if (stat.div_done) begin
					state_nxt = S_FREE_PUSH;
				end
			end
			S_FREE_PUSH: state_nxt = S_IDLE;
			default:     state_nxt = S_INIT;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.res       = RES_NONE;
		busy          = (state_q != S_IDLE) || round_act_q;
		case (state_q)
			S_INIT:   cmd.init = 1'b1;
			S_CLEAR:  cmd.sweep = 1'b1;
			S_IDLE:   cmd.accept = start && !round_act_q;
			S_POP_RD: begin
				if (!stat.top_ok) begin
					cmd.finish = 1'b1;
				end
			end
			S_POP_WR: cmd.pop = 1'b1;
			S_POP_SUM: begin
				cmd.finish = 1'b1;
				cmd.res    = RES_ALLOC;
			end
			S_FREE_CHK: begin
				if (stat.addr_ok) begin
					cmd.div_free = 1'b1;
				end else begin
					cmd.finish = 1'b1;
				end
			end
			S_FREE_DIV: begin
			end
			S_FREE_PUSH: begin
				cmd.finish = 1'b1;
				if (stat.idx_ok) begin
					cmd.push = 1'b1;
					cmd.res  = RES_FREE;
				end
			end
			default: begin
			end
		endcase
	end

	// An item is only taken when no operation or size rounding is in flight.
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> (state_q == S_IDLE) && !round_act_q)
		else $error("item accepted while the controller was occupied");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.sweep, cmd.pop, cmd.push}))
		else $error("more than one writer on the next-index table");

	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> state_q == S_IDLE)
		else $error("controller did not return to idle after a result");

	a_div_follow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_free |=> state_q == S_FREE_DIV)
		else $error("free division started without waiting on the divider");

endmodule

FILE: hdl/fbfa_dp.sv
// Datapath of the allocator: registers, next-index table, divider and result registers.
module fbfa_dp #(
	parameter int MAX_BLOCKS = 1024,
	parameter int LINE_BYTES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fbfa_pkg::ctrl_cmd_t            cmd,
	output fbfa_pkg::ctrl_stat_t           stat,
	input  logic                           cfg_we,
	input  logic [fbfa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fbfa_pkg::ADDR_W-1:0]    cfg_data,
	input  logic                           opcode,
	input  logic [fbfa_pkg::ADDR_W-1:0]    address,
	output logic                           done,
	output logic                           granted,
	output logic [fbfa_pkg::ADDR_W-1:0]    block_address,
	output logic                           free_accepted,
	output logic [fbfa_pkg::CNT_W-1:0]     free_blocks
);
	import fbfa_pkg::*;

	localparam int AW         = $clog2(MAX_BLOCKS);
	localparam int IW         = $clog2(MAX_BLOCKS) + 1;
	localparam int LW         = $clog2(LINE_BYTES + 1);
	localparam int PW         = AW + SIZE_W;
	localparam int RW         = SIZE_W + LW;
	localparam int RESET_SIZE = ((64 + LINE_BYTES - 1) / LINE_BYTES) * LINE_BYTES;
	localparam logic [IW-1:0] END_MARK = IW'(MAX_BLOCKS);
	// Reciprocal of the line size, exact for every dividend below 2**SIZE_W.
	localparam int RK  = SIZE_W + $clog2(LINE_BYTES);
	localparam int RMW = SIZE_W + 1;
	localparam int RPW = SIZE_W + RMW;
	localparam longint unsigned RECIP_RAW =
		((64'd1 << RK) + 64'(LINE_BYTES - 1)) / 64'(LINE_BYTES);
	localparam logic [RMW-1:0] RECIP_M = RMW'(RECIP_RAW);

	logic [ADDR_W-1:0] base_q;
	logic [BB_W-1:0]   bb_q;
	logic [CNT_W-1:0]  biu_q;
	logic [SIZE_W-1:0] size_q;
	logic [IW-1:0]     n;

	logic [IW-1:0]     top_q;
	logic [IW-1:0]     cnt_q;
	logic [IW-1:0]     cnt_nxt;
	logic [IW-1:0]     sweep_q;
	logic [IW-1:0]     sweep_inc;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] prod_q;
	logic [PW-1:0]     prod;
	logic [RW-1:0]     rprod;
	logic [SIZE_W-1:0] round_in;
	logic [RPW-1:0]    recip_prod;
	logic [SIZE_W-1:0] rq_s1;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [IW-1:0]     ram_wdata;
	logic [IW-1:0]     ram_rdata;

	logic              div_start;
	logic [ADDR_W-1:0] div_dividend;
	logic [SIZE_W-1:0] div_divisor;
	logic              div_done;
	logic [ADDR_W-1:0] quo;
	logic [BB_W-1:0]   bb_eff;

	logic              done_q;
	logic              granted_q;
	logic [ADDR_W-1:0] block_address_q;
	logic              free_accepted_q;
	logic [CNT_W-1:0]  free_blocks_q;

	// Block size rounding: the line count comes from a reciprocal multiply, and the
	// rounded size is registered from it in the next cycle.
	assign bb_eff     = (bb_q == '0) ? BB_W'(1) : bb_q;
	assign round_in   = SIZE_W'(bb_eff) + SIZE_W'(LINE_BYTES - 1);
	assign recip_prod = RPW'(round_in) * RPW'(RECIP_M);
	assign rprod      = RW'(rq_s1) * RW'(LINE_BYTES);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			bb_q   <= BB_W'(64);
			biu_q  <= CNT_W'(1024);
			rq_s1  <= SIZE_W'(RESET_SIZE / LINE_BYTES);
			size_q <= SIZE_W'(RESET_SIZE);
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_POOL_BASE:     base_q <= cfg_data;
					REG_BLOCK_BYTES:   bb_q   <= cfg_data[BB_W-1:0];
					REG_BLOCKS_IN_USE: biu_q  <= cfg_data[CNT_W-1:0];
					default: begin
					end
				endcase
			end
			rq_s1  <= SIZE_W'(recip_prod >> RK);
			size_q <= rprod[SIZE_W-1:0];
		end
	end

	// Effective block count, clamped to one through the table depth.
	always_comb begin
		if (biu_q == '0) begin
			n = IW'(1);
		end else if (32'(biu_q) > 32'(MAX_BLOCKS)) begin
			n = END_MARK;
		end else begin
			n = IW'(biu_q);
		end
	end

	assign sweep_inc = sweep_q + 1'b1;

	always_comb begin
		cnt_nxt = cnt_q;
		if (cmd.init) begin
			cnt_nxt = n;
		end else if (cmd.pop && (cnt_q != '0)) begin
			cnt_nxt = cnt_q - 1'b1;
		end else if (cmd.push && (cnt_q < n)) begin
			cnt_nxt = cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q   <= '0;
			cnt_q   <= '0;
			sweep_q <= '0;
		end else begin
			cnt_q <= cnt_nxt;
			if (cmd.init) begin
				top_q   <= '0;
				sweep_q <= '0;
			end else begin
				if (cmd.sweep) begin
					sweep_q <= sweep_inc;
				end
				if (cmd.pop) begin
					top_q <= ram_rdata;
				end else if (cmd.push) begin
					top_q <= IW'(quo[AW-1:0]);
				end
			end
		end
	end

	assign prod = PW'(top_q[AW-1:0]) * PW'(size_q);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q <= address;
		end
		if (cmd.pop) begin
			prod_q <= ADDR_W'(prod);
		end
	end

	// Next-index table write port: clearing sweep, pop mark or push link.
	always_comb begin
		ram_we    = cmd.sweep || cmd.pop || cmd.push;
		ram_waddr = top_q[AW-1:0];
		ram_wdata = END_MARK;
		if (cmd.sweep) begin
			ram_waddr = sweep_q[AW-1:0];
			ram_wdata = (sweep_inc == n) ? END_MARK : sweep_inc;
		end else if (cmd.push) begin
			ram_waddr = quo[AW-1:0];
			ram_wdata = top_q;
		end
	end

	fbfa_ram #(
		.WIDTH(IW),
		.DEPTH(MAX_BLOCKS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(top_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	// The divider turns the offset of a freed address into a block index.
	assign div_start    = cmd.div_free;
	assign div_dividend = addr_q - base_q;
	assign div_divisor  = size_q;

	fbfa_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.done    (div_done),
		.quotient(quo)
	);

	always_comb begin
		stat            = '0;
		stat.size_wr    = cfg_we && (cfg_index == REG_BLOCK_BYTES);
		stat.count_wr   = cfg_we && (cfg_index == REG_BLOCKS_IN_USE);
		stat.op_free    = (opcode == OP_FREE);
		stat.top_ok     = (top_q < n);
		stat.addr_ok    = (addr_q != '0) && (addr_q >= base_q);
		stat.idx_ok     = (quo < ADDR_W'(n));
		stat.div_done   = div_done;
		stat.sweep_last = (sweep_inc == n);
	end

	// Result registers; each result is shown for one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			granted_q       <= (cmd.res == RES_ALLOC);
			block_address_q <= (cmd.res == RES_ALLOC) ? (base_q + prod_q) : '0;
			free_accepted_q <= (cmd.res == RES_FREE);
			free_blocks_q   <= CNT_W'(cnt_nxt);
		end
	end

	assign done          = done_q;
	assign granted       = granted_q;
	assign block_address = block_address_q;
	assign free_accepted = free_accepted_q;
	assign free_blocks   = free_blocks_q;

	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep |-> sweep_q < n)
		else $error("clearing sweep ran past the block count");

endmodule

FILE: hdl/fixed_block_free_list_allocator_unit.sv
// Top level of the fixed block free-list allocator.
//
//   Channel   Handshake              Fields
//   --------  ---------------------  ---------------------------------------------------
//   request   start & !busy          opcode, address
//   result    done (one cycle)       granted, block_address, free_accepted, free_blocks
//   config    cfg_we                 cfg_index, cfg_data
//
// An allocate runs from the accepting edge through table read, table write with the index
// multiply and base add to the result strobe. A free waits on the divider, which turns the
// address offset into an index one quotient bit per cycle. After reset, and after a
// blocks_in_use write while idle or clearing, a clearing pass rebuilds the chain at one
// table entry per cycle over N entries, N the clamped block count (1024 after reset).
// A block_bytes write rounds the size in a two-stage multiply; busy is high for one cycle.
// The result is a one-cycle transfer; the receiver cannot stall the block.
module fixed_block_free_list_allocator_unit #(
	parameter int MAX_BLOCKS = 1024,
	parameter int LINE_BYTES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           opcode,
	input  logic [fbfa_pkg::ADDR_W-1:0]    address,
	input  logic                           cfg_we,
	input  logic [fbfa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fbfa_pkg::ADDR_W-1:0]    cfg_data,
	output logic                           done,
	output logic                           granted,
	output logic [fbfa_pkg::ADDR_W-1:0]    block_address,
	output logic                           free_accepted,
	output logic [fbfa_pkg::CNT_W-1:0]     free_blocks
);
	import fbfa_pkg::*;

	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	fbfa_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.stat  (stat),
		.cmd   (cmd)
	);

	fbfa_dp #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.LINE_BYTES(LINE_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.opcode       (opcode),
		.address      (address),
		.done         (done),
		.granted      (granted),
		.block_address(block_address),
		.free_accepted(free_accepted),
		.free_blocks  (free_blocks)
	);

endmodule
